### hdl/bhm_pkg.sv
// Shared types, codes and helper functions of the bucketed hash map engine.
// No dependencies; every other file refers to this package by scoped names.
package bhm_pkg;

  localparam int KWORDS = 6;
  localparam int WORD_BITS = 64;
  localparam logic [31:0] CRC_POLY = 32'h82F63B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  // Last byte index of the CRC walk for six and for four key words.
  localparam logic [5:0] CRC_LAST_SIX = 6'd47;
  localparam logic [5:0] CRC_LAST_FOUR = 6'd31;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_OCCUPANCY = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_FOUND = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [1:0] MODE_SIX = 2'd0;
  localparam logic [1:0] MODE_FOUR = 2'd1;

  localparam logic CFG_KEY_MODE = 1'b0;
  localparam logic CFG_HASH_KIND = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic cap;
    logic crc_step;
    logic rd_en;
    logic commit;
    logic clr_en;
  } bhm_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic in_crc;
    logic crc_last;
    logic clr_last;
    logic out_busy;
  } bhm_sts_t;

  // One byte through reflected CRC32C, eight shift steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

### hdl/bhm_ctrl.sv
// Sequencing state machine of the bucketed hash map engine.
// Depends on bhm_pkg for the state type and the command and status structs.
module bhm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bhm_pkg::bhm_sts_t sts,
  output bhm_pkg::bhm_cmd_t cmd
);

  bhm_pkg::state_t state, state_next;
  logic report, report_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bhm_pkg::S_CLEAR;
      report <= 1'b0;
    end else begin
      state <= state_next;
      report <= report_next;
    end
  end

  always_comb begin
    state_next = state;
    report_next = report;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      bhm_pkg::S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = report ? bhm_pkg::S_DECIDE : bhm_pkg::S_IDLE;
        end
      end
      bhm_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.cap = 1'b1;
          if (sts.in_clear) begin
            state_next = bhm_pkg::S_CLEAR;
            report_next = 1'b1;
          end else if (sts.in_crc) begin
            state_next = bhm_pkg::S_HASH;
          end else begin
            state_next = bhm_pkg::S_READ;
          end
        end
      end
      bhm_pkg::S_HASH: begin
        cmd.crc_step = 1'b1;
        if (sts.crc_last) begin
          state_next = bhm_pkg::S_READ;
        end
      end
      bhm_pkg::S_READ: begin
        cmd.rd_en = 1'b1;
        state_next = bhm_pkg::S_DECIDE;
      end
      bhm_pkg::S_DECIDE: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          report_next = 1'b0;
          state_next = bhm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bhm_pkg::S_IDLE;
      end
    endcase
  end

  // The input side is closed for the whole clearing sweep.
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == bhm_pkg::S_CLEAR) |-> in_stall)
    else $error("input open during clearing sweep");
  // A commit always returns the machine to idle.
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (state == bhm_pkg::S_IDLE))
    else $error("commit did not return to idle");
  // The hash walk is only entered from a captured item.
  a_hash_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == bhm_pkg::S_HASH) |-> $past(cmd.cap))
    else $error("hash walk entered without a capture");

endmodule

### hdl/bhm_datapath.sv
// Datapath of the bucketed hash map engine: item registers, hash unit,
// bucket memories, key compare and output register. Depends on bhm_pkg.
module bhm_datapath #(
  parameter int HASH_BITS = 10,
  parameter int WAYS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  bhm_pkg::bhm_cmd_t cmd,
  output bhm_pkg::bhm_sts_t sts,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [1:0]        cfg_data,
  input  logic [2:0]        op,
  input  logic              use_given_hash,
  input  logic [15:0]       given_hash,
  input  logic [63:0]       key_creation_seconds,
  input  logic [63:0]       key_sequence,
  input  logic [63:0]       key_node,
  input  logic [63:0]       key_service,
  input  logic [63:0]       key_fragment_offset,
  input  logic [63:0]       key_data_length,
  input  logic [63:0]       value_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [63:0]       value_out,
  output logic [4:0]        bucket_count,
  output logic [15:0]       bucket_index
);

  localparam int NBUCKETS = 1 << HASH_BITS;
  localparam int KEY_BITS = bhm_pkg::KWORDS * bhm_pkg::WORD_BITS;

  logic [1:0] key_mode;
  logic hash_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode <= 2'd0;
      hash_kind <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == bhm_pkg::CFG_KEY_MODE) key_mode <= cfg_data;
      else hash_kind <= cfg_data[0];
    end
  end

  // Captured item. Words the mode does not use are stored as zero.
  logic [2:0] op_r;
  logic given_r;
  logic [15:0] given_hash_r;
  logic [63:0] key_r [bhm_pkg::KWORDS];
  logic [63:0] value_r;
  logic [KEY_BITS-1:0] key_cat;
  logic four_ok, six_ok;

  assign six_ok = (key_mode == bhm_pkg::MODE_SIX);
  assign four_ok = six_ok || (key_mode == bhm_pkg::MODE_FOUR);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r <= op;
      given_r <= use_given_hash;
      given_hash_r <= given_hash;
      key_r[0] <= key_creation_seconds;
      key_r[1] <= four_ok ? key_sequence : 64'd0;
      key_r[2] <= four_ok ? key_node : 64'd0;
      key_r[3] <= four_ok ? key_service : 64'd0;
      key_r[4] <= six_ok ? key_fragment_offset : 64'd0;
      key_r[5] <= six_ok ? key_data_length : 64'd0;
      value_r <= value_in;
    end
  end

  always_comb begin
    for (int i = 0; i < bhm_pkg::KWORDS; i++) begin
      key_cat[i*bhm_pkg::WORD_BITS +: bhm_pkg::WORD_BITS] = key_r[i];
    end
  end

  // CRC walk, one key byte per cycle, lowest byte of each word first.
  logic [31:0] crc;
  logic [5:0] crc_cnt;
  logic [63:0] crc_word;

  assign crc_word = key_r[crc_cnt[5:3]];

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      crc <= bhm_pkg::CRC_INIT;
      crc_cnt <= 6'd0;
    end else if (cmd.crc_step) begin
      crc <= bhm_pkg::crc_byte(crc, crc_word[crc_cnt[2:0]*8 +: 8]);
      crc_cnt <= crc_cnt + 6'd1;
    end
  end

  // Selected hash.
  logic [63:0] x64;
  logic [31:0] x32;
  logic [15:0] hash;
  logic [HASH_BITS-1:0] bucket;

  always_comb begin
    x64 = '0;
    for (int i = 0; i < bhm_pkg::KWORDS; i++) x64 = x64 ^ key_r[i];
    x32 = x64[63:32] ^ x64[31:0];
    if (given_r || (op_r == bhm_pkg::OP_OCCUPANCY)) hash = given_hash_r;
    else if (!four_ok) hash = key_r[0][15:0];
    else if (hash_kind) hash = crc[31:16] ^ crc[15:0];
    else hash = x32[31:16] ^ x32[15:0];
  end

  assign bucket = hash[HASH_BITS-1:0];

  // Clearing sweep counter.
  logic [HASH_BITS-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_en) clr_cnt <= clr_cnt + 1'b1;
  end

  // Bucket memories, one row per bucket.
  logic [WAYS-1:0] valid_mem [NBUCKETS];
  logic [WAYS*KEY_BITS-1:0] key_mem [NBUCKETS];
  logic [WAYS*64-1:0] val_mem [NBUCKETS];
  logic [WAYS-1:0] rd_valid;
  logic [WAYS*KEY_BITS-1:0] rd_keys;
  logic [WAYS*64-1:0] rd_vals;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_valid <= valid_mem[bucket];
      rd_keys <= key_mem[bucket];
      rd_vals <= val_mem[bucket];
    end
  end

  // Compare and decide.
  logic [WAYS-1:0] hit_oh, free_oh, new_valid;
  logic [WAYS*KEY_BITS-1:0] new_keys;
  logic [WAYS*64-1:0] new_vals;
  logic hit_any, free_any, do_insert, do_remove;
  logic [63:0] hit_val;
  logic [4:0] count;
  logic [2:0] st;

  always_comb begin
    hit_oh = '0;
    free_oh = '0;
    hit_any = 1'b0;
    free_any = 1'b0;
    hit_val = 64'd0;
    for (int w = 0; w < WAYS; w++) begin
      if (!rd_valid[w]) begin
        if (!free_any) free_oh[w] = 1'b1;
        free_any = 1'b1;
      end else if (!hit_any && (rd_keys[w*KEY_BITS +: KEY_BITS] == key_cat)) begin
        hit_oh[w] = 1'b1;
        hit_any = 1'b1;
        hit_val = rd_vals[w*64 +: 64];
      end
    end
    do_insert = (op_r == bhm_pkg::OP_INSERT) && !hit_any && free_any;
    do_remove = (op_r == bhm_pkg::OP_REMOVE) && hit_any;
    new_valid = rd_valid;
    new_keys = rd_keys;
    new_vals = rd_vals;
    for (int w = 0; w < WAYS; w++) begin
      if (do_insert && free_oh[w]) begin
        new_valid[w] = 1'b1;
        new_keys[w*KEY_BITS +: KEY_BITS] = key_cat;
        new_vals[w*64 +: 64] = value_r;
      end
      if (do_remove && hit_oh[w]) new_valid[w] = 1'b0;
    end
    count = 5'd0;
    for (int w = 0; w < WAYS; w++) count = count + {4'd0, new_valid[w]};
    case (op_r)
      bhm_pkg::OP_INSERT: begin
        st = hit_any ? bhm_pkg::ST_PRESENT : (free_any ? bhm_pkg::ST_INSERTED
                                                        : bhm_pkg::ST_FULL);
      end
      bhm_pkg::OP_LOOKUP, bhm_pkg::OP_REMOVE: begin
        st = hit_any ? bhm_pkg::ST_FOUND : bhm_pkg::ST_NOT_FOUND;
      end
      default: st = bhm_pkg::ST_DONE;
    endcase
  end

  logic is_clear_r;
  assign is_clear_r = (op_r == bhm_pkg::OP_CLEAR);

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      valid_mem[clr_cnt] <= '0;
    end else if (cmd.commit && !is_clear_r) begin
      valid_mem[bucket] <= new_valid;
    end
    if (cmd.commit && do_insert) begin
      key_mem[bucket] <= new_keys;
      val_mem[bucket] <= new_vals;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.commit) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (is_clear_r) begin
        status <= bhm_pkg::ST_DONE;
        value_out <= 64'd0;
        bucket_count <= 5'd0;
        bucket_index <= 16'd0;
      end else begin
        status <= st;
        value_out <= (((op_r == bhm_pkg::OP_LOOKUP) || (op_r == bhm_pkg::OP_REMOVE))
                      && hit_any) ? hit_val : 64'd0;
        bucket_count <= count;
        bucket_index <= hash;
      end
    end
  end

  always_comb begin
    sts.in_clear = (op == bhm_pkg::OP_CLEAR);
    sts.in_crc = (op != bhm_pkg::OP_CLEAR) && (op != bhm_pkg::OP_OCCUPANCY) &&
                 !use_given_hash && hash_kind && four_ok;
    sts.crc_last = crc_cnt == (six_ok ? bhm_pkg::CRC_LAST_SIX : bhm_pkg::CRC_LAST_FOUR);
    sts.clr_last = (clr_cnt == {HASH_BITS{1'b1}});
    sts.out_busy = out_valid && out_stall;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("result register overwritten while held");
  a_single_way: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> ($onehot0(hit_oh) && $onehot0(free_oh) && !(|(hit_oh & free_oh))))
    else $error("more than one way selected");
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !is_clear_r && (op_r == bhm_pkg::OP_INSERT) && hit_any)
      |=> (status == bhm_pkg::ST_PRESENT) && (bucket_count != 5'd0))
    else $error("duplicate insert reported with empty bucket");

endmodule

### hdl/bucketed_hash_map_engine_top.sv
// Top level of the bucketed hash map engine.
// Depends on bhm_pkg, bhm_ctrl and bhm_datapath.
//
//   Channel   Handshake           Payload
//   input     in_valid/in_stall   op, use_given_hash, given_hash, six key words, value_in
//   output    out_valid/out_stall status, value_out, bucket_count, bucket_index
//   config    cfg_we              cfg_index, cfg_data
//
// An item without CRC hashing goes from transfer to result through capture,
// bucket read, and decide with write-back. With CRC hashing the byte-serial CRC unit
// adds a walk over the bytes of the four or six key words, between capture and read.
// After reset, and for a clear operation, a sweep clears one bucket row per cycle,
// all 2**HASH_BITS rows (1024 by default); no item is taken meanwhile.
// The input side is stalled from capture until the result has been loaded into the
// output register; a stalled result only holds back the next item's final step.
module bucketed_hash_map_engine_top #(
  parameter int HASH_BITS = 10,
  parameter int WAYS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic        use_given_hash,
  input  logic [15:0] given_hash,
  input  logic [63:0] key_creation_seconds,
  input  logic [63:0] key_sequence,
  input  logic [63:0] key_node,
  input  logic [63:0] key_service,
  input  logic [63:0] key_fragment_offset,
  input  logic [63:0] key_data_length,
  input  logic [63:0] value_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [63:0] value_out,
  output logic [4:0]  bucket_count,
  output logic [15:0] bucket_index,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);

  bhm_pkg::bhm_cmd_t cmd;
  bhm_pkg::bhm_sts_t sts;

  // The controller sequences each transfer; the datapath does all the work.
  bhm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bhm_datapath #(
    .HASH_BITS (HASH_BITS),
    .WAYS      (WAYS)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .op                   (op),
    .use_given_hash       (use_given_hash),
    .given_hash           (given_hash),
    .key_creation_seconds (key_creation_seconds),
    .key_sequence         (key_sequence),
    .key_node             (key_node),
    .key_service          (key_service),
    .key_fragment_offset  (key_fragment_offset),
    .key_data_length      (key_data_length),
    .value_in             (value_in),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .status               (status),
    .value_out            (value_out),
    .bucket_count         (bucket_count),
    .bucket_index         (bucket_index)
  );

endmodule
